// ===== hw/rtl/gtif_pkg.sv =====
package gtif_pkg;

    // Field widths
    localparam int MODE_W    = 2;
    localparam int STAMP_W   = 64;
    localparam int VOLT_W    = 16;
    localparam int GAP_W     = 32;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_CLOSE  = 2'd1,
        MODE_EVENT  = 2'd2
    } mode_t;

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIM  = 1'd1;

    // Register reset values
    localparam logic signed [VOLT_W-1:0] VOLT_THR_RST = -16'sd800;
    localparam logic [GAP_W-1:0]         GAP_LIM_RST  = 32'd65536;

    // Engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] volt_thr;
        logic [GAP_W-1:0]         gap_lim;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic               keep;
        logic [STAMP_W-1:0] event_stamp;
        logic [COUNT_W-1:0] interval_count;
        logic               overflowed;
    } res_t;

endpackage

// ===== hw/rtl/gtif_ifs.sv =====
interface gtif_in_if;
    import gtif_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [STAMP_W-1:0]       stamp;
    logic signed [VOLT_W-1:0] voltage;

    modport source (output valid, mode, stamp, voltage, input ready);
    modport sink   (input valid, mode, stamp, voltage, output ready);
endinterface

interface gtif_out_if;
    import gtif_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic               keep;
    logic [STAMP_W-1:0] event_stamp;
    logic [COUNT_W-1:0] interval_count;
    logic               overflowed;

    modport source (output valid, kind, keep, event_stamp, interval_count, overflowed,
                    input ready);
    modport sink   (input valid, kind, keep, event_stamp, interval_count, overflowed,
                    output ready);
endinterface

// ===== hw/rtl/gtif_table_ram.sv =====
module gtif_table_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 128
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/gtif_engine.sv =====
module gtif_engine #(
    parameter int MAX_INTERVALS = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gtif_pkg::cfg_t  cfg,
    gtif_in_if.sink         in_ch,
    output gtif_pkg::res_t  res,
    output logic            res_valid,
    input  logic            res_ready
);
    import gtif_pkg::*;

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               open_reg, open_next;
    logic [STAMP_W-1:0] open_start_reg, open_start_next;
    logic [STAMP_W-1:0] last_reg, last_next;
    logic               closed_reg, closed_next;
    logic               ovf_reg, ovf_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               kind_reg, kind_next;
    logic               keep_reg, keep_next;
    logic [CW-1:0]      cmp_idx_reg, cmp_idx_next;

    logic                 accept;
    logic                 qualifies;
    logic                 gap_break;
    logic [STAMP_W-1:0]   step;
    logic [CW-1:0]        count_eff;
    logic                 open_eff;
    logic [CW-1:0]        nxt_idx;
    logic                 hit;
    logic [CW+COUNT_W-1:0] count_wide;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [2*STAMP_W-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [2*STAMP_W-1:0] mem_rdata;

    // Interval table: start in the upper half, end in the lower half
    gtif_table_ram #(
        .DEPTH  (MAX_INTERVALS),
        .ADDR_W (AW),
        .DATA_W (2*STAMP_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // A sample after a close sees an empty table
    assign count_eff = closed_reg ? '0 : count_reg;
    assign open_eff  = closed_reg ? 1'b0 : open_reg;

    assign qualifies = (in_ch.voltage <= cfg.volt_thr);
    assign step      = in_ch.stamp - last_reg;
    assign gap_break = (in_ch.stamp > last_reg) && (step > {{(STAMP_W-GAP_W){1'b0}}, cfg.gap_lim});

    // Scan compare on the registered read word
    assign nxt_idx = cmp_idx_reg + 1'b1;
    assign hit     = (stamp_reg >= mem_rdata[2*STAMP_W-1:STAMP_W]) &&
                     (stamp_reg <= mem_rdata[STAMP_W-1:0]);

    // Result word
    assign count_wide          = {{COUNT_W{1'b0}}, count_reg};
    assign res.kind            = kind_reg;
    assign res.keep            = keep_reg;
    assign res.event_stamp     = stamp_reg;
    assign res.interval_count  = count_wide[COUNT_W-1:0];
    assign res.overflowed      = ovf_reg;
    assign res_valid           = (state_reg == ST_PUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            open_reg       <= 1'b0;
            open_start_reg <= '0;
            last_reg       <= '0;
            closed_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            cmp_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            open_start_reg <= open_start_next;
            last_reg       <= last_next;
            closed_reg     <= closed_next;
            ovf_reg        <= ovf_next;
            cmp_idx_reg    <= cmp_idx_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        kind_reg  <= kind_next;
        keep_reg  <= keep_next;
    end

    // Next state, table writes and scan reads. Only one item is in flight,
    // so a table write never overlaps a read of the same entry.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        open_start_next = open_start_reg;
        last_next       = last_reg;
        closed_next     = closed_reg;
        ovf_next        = ovf_reg;
        stamp_next      = stamp_reg;
        kind_next       = kind_reg;
        keep_next       = keep_reg;
        cmp_idx_next    = cmp_idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_eff[AW-1:0];
        mem_wdata       = {open_start_reg, last_reg};
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode_t'(in_ch.mode))
                        MODE_SAMPLE:
                        begin
                            if (closed_reg)
                            begin
                                count_next  = '0;
                                ovf_next    = 1'b0;
                                open_next   = 1'b0;
                                closed_next = 1'b0;
                            end
                            if (qualifies)
                            begin
                                if (!open_eff)
                                begin
                                    open_next       = 1'b1;
                                    open_start_next = in_ch.stamp;
                                end
                                else if (gap_break)
                                begin
                                    if (count_eff < MAX_CNT)
                                    begin
                                        mem_we     = 1'b1;
                                        count_next = count_eff + 1'b1;
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    open_start_next = in_ch.stamp;
                                end
                                last_next = in_ch.stamp;
                            end
                        end
                        MODE_CLOSE:
                        begin
                            if (open_reg)
                            begin
                                if (count_eff < MAX_CNT)
                                begin
                                    mem_we     = 1'b1;
                                    count_next = count_eff + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                open_next = 1'b0;
                            end
                            closed_next = 1'b1;
                            kind_next   = KIND_SUMMARY;
                            keep_next   = 1'b0;
                            stamp_next  = '0;
                            state_next  = ST_PUSH;
                        end
                        MODE_EVENT:
                        begin
                            kind_next    = KIND_VERDICT;
                            keep_next    = 1'b0;
                            stamp_next   = in_ch.stamp;
                            cmp_idx_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = ST_PUSH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Fetch the following entry while comparing the current one
                mem_re    = 1'b1;
                mem_raddr = nxt_idx[AW-1:0];
                if (hit)
                begin
                    keep_next  = 1'b1;
                    state_next = ST_PUSH;
                end
                else if (nxt_idx == count_reg)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmp_idx_next = nxt_idx;
                end
            end
            ST_PUSH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== hw/rtl/good_time_interval_event_filter_core.sv =====
// Good time interval event filter.
// Input channel in_ch carries one word per item: mode 0 is a housekeeping
// sample (stamp, voltage), mode 1 closes the interval table, mode 2 tests an
// event stamp. Mode 3 is dropped. Output channel out_ch carries one word for
// each close (summary) and each event (verdict); samples produce nothing.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, and the block does not enforce this. One item
// is handled at a time. A sample is taken in the idle state. A close passes its
// summary through the push state and the output register. An event walks the
// stored intervals one entry per cycle through the table memory's single read
// port, stopping at the first hit, or at once with an empty table. The next item
// is accepted the cycle after the result is handed to the output register.
// Reset clears the count, flags and state, not the result payload registers;
// table contents are undefined and only entries below the count are compared.
// A stalled receiver holds the word in the output register; one more result
// can wait inside the engine, after which in_ch.ready stays low.
module good_time_interval_event_filter_core #(
    parameter int MAX_INTERVALS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gtif_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gtif_pkg::CFG_DATA_W-1:0]      cfg_data,
    gtif_in_if.sink                              in_ch,
    gtif_out_if.source                           out_ch
);
    import gtif_pkg::*;

    cfg_t cfg_reg;
    res_t eng_res;
    logic eng_valid;
    logic eng_ready;
    res_t out_res_reg;
    logic out_full_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_thr <= VOLT_THR_RST;
            cfg_reg.gap_lim  <= GAP_LIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOLT_THR: cfg_reg.volt_thr <= cfg_data[VOLT_W-1:0];
                CFG_GAP_LIM:  cfg_reg.gap_lim  <= cfg_data[GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gtif_engine #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .res       (eng_res),
        .res_valid (eng_valid),
        .res_ready (eng_ready)
    );

    // Output register
    assign eng_ready = !out_full_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (eng_valid && eng_ready)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && eng_ready)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign out_ch.valid          = out_full_reg;
    assign out_ch.kind           = out_res_reg.kind;
    assign out_ch.keep           = out_res_reg.keep;
    assign out_ch.event_stamp    = out_res_reg.event_stamp;
    assign out_ch.interval_count = out_res_reg.interval_count;
    assign out_ch.overflowed     = out_res_reg.overflowed;
endmodule

// ===== hw/rtl/gtif_checker.sv =====
module gtif_checker #(
    parameter int MAX_INTERVALS = 256
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               out_kind,
    input logic                               out_keep,
    input logic [gtif_pkg::STAMP_W-1:0]       out_stamp,
    input logic [gtif_pkg::COUNT_W-1:0]       out_count,
    input logic                               out_ovf
);
    import gtif_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT9 = COUNT_W'(MAX_INTERVALS);
    localparam bit                 CNT_WRAPS = (MAX_INTERVALS >= 512);

    // A stalled word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // Summaries carry no verdict and no stamp
    a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_SUMMARY) |-> !out_keep && (out_stamp == '0))
        else $error("summary word carries event fields");

    // A kept event needs a stored interval
    a_keep_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_keep |-> (out_kind == KIND_VERDICT) && (CNT_WRAPS || out_count != '0))
        else $error("event kept with empty table");

    // Overflow only once the table is full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ovf |-> out_count == MAX_CNT9)
        else $error("overflow reported with table not full");
endmodule

bind good_time_interval_event_filter_core gtif_checker #(
    .MAX_INTERVALS (MAX_INTERVALS)
) u_gtif_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_keep  (out_ch.keep),
    .out_stamp (out_ch.event_stamp),
    .out_count (out_ch.interval_count),
    .out_ovf   (out_ch.overflowed)
);

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gtif_pkg::*;

    localparam int                 GTI_DEPTH      = 256;
    localparam int                 HANG_LIMIT     = 3000;
    localparam int                 SETTLE_CYCLES  = 8;
    localparam int                 SQUEEZE_CYCLES = 400;
    localparam int                 PHASE_WORDS    = 330;
    localparam logic [MODE_W-1:0]  MODE_UNUSED    = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_MAX      = '1;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic [STAMP_W-1:0]       stamp;
        logic signed [VOLT_W-1:0] voltage;
    } hk_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gtif_in_if  in_ch ();
    gtif_out_if out_ch ();

    good_time_interval_event_filter_core #(
        .MAX_INTERVALS (GTI_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // words waiting to be sent, results still owed by the block
    hk_word_t           words_to_send [$];
    res_t               verdicts_due [$];
    logic [STAMP_W-1:0] session_marks [$];
    int                 error_count;
    int                 words_queued;
    int                 squeeze_seq;
    int                 squeeze_seen;
    int                 hold_left;
    int                 burst_left;
    int                 idle_left;
    int                 stuck_cycles;
    logic [15:0]        stall_tick;

    // shadow of the interval table, the open run and the registers
    logic [STAMP_W-1:0]       gti_start [GTI_DEPTH];
    logic [STAMP_W-1:0]       gti_end [GTI_DEPTH];
    int unsigned              gti_count;
    bit                       run_open;
    bit                       table_closed;
    bit                       table_over;
    logic [STAMP_W-1:0]       run_start;
    logic [STAMP_W-1:0]       run_last;
    logic signed [VOLT_W-1:0] thr_model;
    logic [GAP_W-1:0]         gap_model;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic gti_store(logic [STAMP_W-1:0] lo, logic [STAMP_W-1:0] hi);
        if (gti_count < GTI_DEPTH)
        begin
            gti_start[gti_count] = lo;
            gti_end[gti_count]   = hi;
            gti_count++;
        end
        else
            table_over = 1'b1;
    endtask

    // Advance the table shadow by one accepted word, queue the result it owes
    task automatic gti_track(logic [MODE_W-1:0] mode, logic [STAMP_W-1:0] stamp,
                             logic signed [VOLT_W-1:0] voltage);
        res_t word;
        bit   hit;
        int   idx;
        word = '0;
        hit  = 1'b0;
        if (mode == MODE_SAMPLE)
        begin
            // any sample after a close starts a fresh table
            if (table_closed)
            begin
                gti_count    = 0;
                table_over   = 1'b0;
                run_open     = 1'b0;
                table_closed = 1'b0;
            end
            if (voltage <= thr_model)
            begin
                if (!run_open)
                begin
                    run_open  = 1'b1;
                    run_start = stamp;
                end
                else if (stamp > run_last && (stamp - run_last) > STAMP_W'(gap_model))
                begin
                    gti_store(run_start, run_last);
                    run_start = stamp;
                end
                run_last = stamp;
            end
        end
        else if (mode == MODE_CLOSE)
        begin
            if (run_open)
            begin
                gti_store(run_start, run_last);
                run_open = 1'b0;
            end
            table_closed        = 1'b1;
            word.kind           = KIND_SUMMARY;
            word.interval_count = COUNT_W'(gti_count);
            word.overflowed     = table_over;
            verdicts_due        = {verdicts_due, word};
        end
        else if (mode == MODE_EVENT)
        begin
            // only stored intervals count, the open run does not
            for (idx = 0; idx < gti_count && !hit; idx++)
                if (stamp >= gti_start[idx] && stamp <= gti_end[idx])
                    hit = 1'b1;
            word.kind           = KIND_VERDICT;
            word.keep           = hit;
            word.event_stamp    = stamp;
            word.interval_count = COUNT_W'(gti_count);
            word.overflowed     = table_over;
            verdicts_due        = {verdicts_due, word};
        end
    endtask

    task automatic push_word(logic [MODE_W-1:0] mode, logic [STAMP_W-1:0] stamp,
                             logic signed [VOLT_W-1:0] voltage);
        hk_word_t w;
        w.mode        = mode;
        w.stamp       = stamp;
        w.voltage     = voltage;
        words_to_send = {words_to_send, w};
        if (mode != MODE_UNUSED)
            words_queued++;
    endtask

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    // voltage at or below the threshold when qualify is set or the threshold is at its top, above it otherwise
    function automatic logic signed [VOLT_W-1:0] pick_voltage(bit qualify);
        int lim;
        lim = thr_model;
        if (qualify || lim == 32767)
            return VOLT_W'(lim - int'($urandom_range(0, lim + 32768)));
        return VOLT_W'(lim + 1 + int'($urandom_range(0, 32766 - lim)));
    endfunction

    // event time near a qualifying time of this session, or anywhere
    function automatic logic [STAMP_W-1:0] pick_event();
        logic [STAMP_W-1:0] base;
        if (session_marks.size() == 0 || $urandom_range(0, 5) == 0)
            return rand_stamp();
        base = session_marks[$urandom_range(0, session_marks.size() - 1)];
        case ($urandom_range(0, 4))
            0: return base + 1;
            1: return base - 1;
            2: return base + STAMP_W'($urandom_range(0, gap_model));
            default: return base;
        endcase
    endfunction

    // One table build: samples, maybe an early event, a close (sometimes repeated), then events against the new table
    task automatic gen_session(int samples, bit chain_breaks);
        logic [STAMP_W-1:0] t;
        logic [STAMP_W-1:0] gap64;
        bit                 qual;
        int                 k;
        int                 n_ev;
        gap64 = STAMP_W'(gap_model);
        session_marks.delete();
        case ($urandom_range(0, 7))
            0: t = STAMP_W'($urandom_range(0, 4096));
            1: t = STAMP_MAX - STAMP_W'($urandom_range(0, 4096));
            default: t = rand_stamp();
        endcase
        for (k = 0; k < samples; k++)
        begin
            if (k > 0)
            begin
                if (chain_breaks)
                    t = t + gap64 + STAMP_W'($urandom_range(1, 4));
                else
                    case ($urandom_range(0, 7))
                        0: t = t;   // repeated time
                        1: t = t + gap64;
                        2: t = t + gap64 + 1;
                        3: t = t + gap64 + 1 + STAMP_W'($urandom_range(0, 100000));
                        4: t = t - STAMP_W'($urandom_range(1, 4096));
                        default: t = t + STAMP_W'($urandom_range(0, gap_model));
                    endcase
            end
            qual = chain_breaks || $urandom_range(0, 7) != 0;
            push_word(MODE_SAMPLE, t, pick_voltage(qual));
            if (qual)
                session_marks = {session_marks, t};
        end
        if ($urandom_range(0, 3) == 0)
            push_word(MODE_EVENT, pick_event(), VOLT_W'($urandom));
        push_word(MODE_CLOSE, rand_stamp(), VOLT_W'($urandom));
        if ($urandom_range(0, 5) == 0)
            push_word(MODE_CLOSE, rand_stamp(), VOLT_W'($urandom));
        n_ev = $urandom_range(1, 8);
        for (k = 0; k < n_ev; k++)
            push_word(MODE_EVENT, pick_event(), VOLT_W'($urandom));
        // noise: dropped mode, fully random words
        if ($urandom_range(0, 9) == 0)
            push_word(MODE_UNUSED, rand_stamp(), VOLT_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            push_word(MODE_W'($urandom_range(0, 2)), rand_stamp(), VOLT_W'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VOLT_THR)
            thr_model = val[VOLT_W-1:0];
        else if (idx == CFG_GAP_LIM)
            gap_model = val[GAP_W-1:0];
    endtask

    // Wait until every word is sent and every result is back, then let the engine settle
    task automatic drain();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || in_ch.valid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic signed [VOLT_W-1:0] thr, logic [GAP_W-1:0] gap,
                             bit squeeze, bit fill_table);
        write_reg(CFG_VOLT_THR, {{(CFG_DATA_W-VOLT_W){1'b0}}, thr});
        write_reg(CFG_GAP_LIM, gap);
        words_queued = 0;
        if (fill_table)
            gen_session(GTI_DEPTH + 6, 1'b1);
        while (words_queued < PHASE_WORDS)
            gen_session($urandom_range(1, 12), 1'b0);
        if (squeeze)
            squeeze_seq++;
        drain();
    endtask

    // Sequencer: reset, directed words, then randomized phases per register setting
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_SAMPLE;
        in_ch.stamp   = '0;
        in_ch.voltage = '0;
        out_ch.ready  = 1'b0;
        error_count   = 0;
        words_queued  = 0;
        squeeze_seq   = 0;
        squeeze_seen  = 0;
        hold_left     = 0;
        burst_left    = 1;
        idle_left     = 0;
        stuck_cycles  = 0;
        stall_tick    = '0;
        gti_count     = 0;
        run_open      = 1'b0;
        table_closed  = 1'b0;
        table_over    = 1'b0;
        run_start     = '0;
        run_last      = '0;
        thr_model     = VOLT_THR_RST;
        gap_model     = GAP_LIM_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, close with nothing open, repeated close, dropped mode
        push_word(MODE_EVENT, '0, '0);
        push_word(MODE_CLOSE, '0, '0);
        push_word(MODE_CLOSE, '0, '0);
        push_word(MODE_UNUSED, STAMP_MAX, -16'sd1);
        // step equal to the gap, time going backwards, a rejected sample, then a break
        push_word(MODE_SAMPLE, '0, -16'sd32768);
        push_word(MODE_SAMPLE, 64'h1_0000, -16'sd800);
        push_word(MODE_SAMPLE, 64'h8000, -16'sd800);
        push_word(MODE_SAMPLE, 64'h3_0000, 16'sd32767);
        push_word(MODE_SAMPLE, 64'h2_0001, -16'sd801);
        // events before the close see only the stored interval
        push_word(MODE_EVENT, 64'h8000, '0);
        push_word(MODE_EVENT, 64'h2_0001, '0);
        push_word(MODE_CLOSE, '0, '0);
        push_word(MODE_EVENT, '0, '0);
        push_word(MODE_EVENT, 64'h8001, '0);
        push_word(MODE_EVENT, 64'h2_0001, '0);
        push_word(MODE_EVENT, 64'h2_0002, '0);
        push_word(MODE_EVENT, STAMP_MAX, '0);
        // rejected sample after close still clears the table
        push_word(MODE_SAMPLE, STAMP_MAX, 16'sd32767);
        push_word(MODE_EVENT, '0, '0);
        push_word(MODE_CLOSE, '0, '0);
        // single point interval at the top of the time range
        push_word(MODE_SAMPLE, STAMP_MAX, -16'sd32768);
        push_word(MODE_CLOSE, '0, '0);
        push_word(MODE_EVENT, STAMP_MAX, '0);
        push_word(MODE_EVENT, STAMP_MAX - 1, '0);
        drain();

        run_phase(-16'sd800, 32'd65536, 1'b1, 1'b0);
        run_phase(16'sd32767, 32'd0, 1'b0, 1'b1);
        run_phase(-16'sd32768, 32'hFFFF_FFFF, 1'b0, 1'b0);
        run_phase(VOLT_W'($urandom), $urandom, 1'b1, 1'b0);
        run_phase(16'sd0, $urandom_range(0, 255), 1'b0, 1'b0);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender: bursts of words with random gaps, prediction on acceptance
    always @(posedge clk)
    begin
        hk_word_t nxt;
        logic     offer;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                gti_track(in_ch.mode, in_ch.stamp, in_ch.voltage);
            if (!in_ch.valid || in_ch.ready)
            begin
                offer = 1'b0;
                if (idle_left > 0)
                    idle_left--;
                else if (words_to_send.size() > 0)
                begin
                    nxt           = words_to_send.pop_front();
                    offer         = 1'b1;
                    in_ch.mode    <= nxt.mode;
                    in_ch.stamp   <= nxt.stamp;
                    in_ch.voltage <= nxt.voltage;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        // long stretch with no gaps
                        burst_left = 150;
                        idle_left  = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
                    end
                end
                in_ch.valid <= offer;
            end
        end
    end

    // Receiver: compare each result word, stall on a rotating pattern
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        logic take;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind           = out_ch.kind;
                got.keep           = out_ch.keep;
                got.event_stamp    = out_ch.event_stamp;
                got.interval_count = out_ch.interval_count;
                got.overflowed     = out_ch.overflowed;
                if (verdicts_due.size() == 0)
                    report_mismatch("unexpected word, stamp", got.event_stamp, '0);
                else
                begin
                    want = verdicts_due.pop_front();
                    check_field("kind", got.kind, want.kind);
                    check_field("keep", got.keep, want.keep);
                    check_field("event_stamp", got.event_stamp, want.event_stamp);
                    check_field("interval_count", got.interval_count, want.interval_count);
                    check_field("overflowed", got.overflowed, want.overflowed);
                end
            end
            stall_tick++;
            // long hold-off so the block backs up onto its input
            if (squeeze_seen != squeeze_seq)
            begin
                squeeze_seen = squeeze_seq;
                hold_left    = SQUEEZE_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
                case (stall_tick[9:7])
                    3'd0, 3'd1: take = 1'b1;
                    3'd2, 3'd3: take = $urandom_range(0, 3) != 0;
                    3'd4:       take = stall_tick[2:0] != 3'b101;
                    3'd5:       take = $urandom_range(0, 1) != 0;
                    3'd6:       take = stall_tick[4];
                    default:    take = ~stall_tick[0];
                endcase
            out_ch.ready <= take;
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles = 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= HANG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
